// File: rtl/hrt_pkg.sv
// Shared types, sizes and codes for the heap range table.
package hrt_pkg;

    // table geometry
    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);

    // field widths
    localparam int ADDR_W  = 64;
    localparam int SIZE_W  = 48;
    localparam int CNT_W   = 32;
    localparam int TOTAL_W = 64;

    localparam logic [SIZE_W-1:0] THRESH_RESET = SIZE_W'(4096);

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_REALLOC = 2'd1,
        OP_FREE    = 2'd2,
        OP_LOOKUP  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_CALC,
        ST_DONE
    } t_state;

    // input word
    typedef struct packed {
        t_op               opcode;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] new_addr;
        logic [SIZE_W-1:0] size;
    } t_req;

    // result word
    typedef struct packed {
        logic               found;
        logic [SIZE_W-1:0]  remaining_size;
        logic               table_full;
        logic [SIZE_W-1:0]  largest_object_out;
        logic [CNT_W-1:0]   alloc_count_out;
        logic [CNT_W-1:0]   big_count_out;
        logic [SIZE_W-1:0]  largest_found_out;
        logic [TOTAL_W-1:0] found_total_out;
    } t_rsp;

    // decoded command held for the whole scan
    typedef struct packed {
        logic              drop_en;
        logic              add_en;
        logic              look_en;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] add_key;
        logic [SIZE_W-1:0] size;
    } t_cmd;

    // scan trackers
    typedef struct packed {
        logic              match_hit;
        logic [IDX_W-1:0]  match_idx;
        logic              free_hit;
        logic [IDX_W-1:0]  free_idx;
        logic              best_hit;
        logic [ADDR_W-1:0] best_start;
        logic [ADDR_W-1:0] best_end;
    } t_track;

    // finished operation handed to the statistics unit
    typedef struct packed {
        logic              commit;
        logic              add_ok;
        logic              full;
        logic              found;
        logic [SIZE_W-1:0] rem;
        logic [SIZE_W-1:0] size;
    } t_fin;

endpackage

// File: rtl/heap_range_table.sv
// Top level: sequencer, table storage, shared adder and configuration register.
// The block takes no new word while busy; busy covers the table scan, one entry per
// cycle through the single RAM read port, a drain state for the registered read, then
// the adder state and the statistics state.
// Reset (synchronous, active low) clears the valid bits and statistics and sets the threshold to 4096.
module heap_range_table import hrt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_req              i_req,
    output logic              o_strobe,
    output t_rsp              o_rsp,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SIZE_W-1:0] i_cfg_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_pend;
    logic [IDX_W-1:0]    r_pend_idx;
    logic [ENTRIES-1:0]  r_valid, n_valid;
    t_cmd                r_cmd, n_cmd;
    logic [SIZE_W-1:0]   r_thresh;
    logic                r_found, r_full, r_add_ok;
    logic [SIZE_W-1:0]   r_rem;

    logic                accept;
    logic                scan_clr;
    logic                drop_hit;
    t_track              trk;
    logic [2*ADDR_W-1:0] rd_data;
    logic                ram_we;
    logic [IDX_W-1:0]    slot;
    logic                full;
    logic [ADDR_W-1:0]   op_a, op_b;
    logic                cin;
    logic [ADDR_W:0]     sum;
    logic [ADDR_W-1:0]   new_end;
    logic                look_found;
    t_fin                fin;

    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign scan_clr    = accept;

    // decode the opcode into drop / add / lookup actions
    always_comb begin
        n_cmd         = '0;
        n_cmd.addr    = i_req.addr;
        n_cmd.add_key = i_req.addr;
        n_cmd.size    = i_req.size;
        case (i_req.opcode)
            OP_ALLOC: begin
                n_cmd.add_en = (i_req.addr != '0);
            end
            OP_REALLOC: begin
                n_cmd.add_key = i_req.new_addr;
                if (i_req.addr == '0) begin
                    n_cmd.add_en = (i_req.new_addr != '0);
                end else if (i_req.size == '0) begin
                    n_cmd.drop_en = 1'b1;
                end else begin
                    n_cmd.drop_en = (i_req.addr != i_req.new_addr)
                                    && (i_req.new_addr != '0);
                    n_cmd.add_en  = (i_req.new_addr != '0);
                end
            end
            OP_FREE: begin
                n_cmd.drop_en = 1'b1;
            end
            OP_LOOKUP: begin
                n_cmd.look_en = 1'b1;
            end
            default: begin
                n_cmd = '0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pend  <= (r_state == ST_SCAN);
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_idx = r_idx + IDX_W'(1);
                if (r_idx == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_CALC;
            ST_CALC:  n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // command, read tag and threshold registers
    always_ff @(posedge i_clk) begin
        r_pend_idx <= r_idx;
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thresh <= i_cfg_data;
        end
    end

    // table storage: start in the upper half, end in the lower half
    hrt_ram #(
        .WIDTH (2*ADDR_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot),
        .i_wdata ({r_cmd.add_key, new_end}),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    hrt_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clr      (scan_clr),
        .i_smp      (r_pend),
        .i_cmd      (r_cmd),
        .i_idx      (r_pend_idx),
        .i_vld      (r_valid[r_pend_idx]),
        .i_start    (rd_data[2*ADDR_W-1:ADDR_W]),
        .i_end      (rd_data[ADDR_W-1:0]),
        .o_drop_hit (drop_hit),
        .o_trk      (trk)
    );

    // shared adder: start + size for alloc and realloc, end - addr for lookup
    always_comb begin
        op_a       = r_cmd.look_en ? trk.best_end : r_cmd.add_key;
        op_b       = r_cmd.look_en ? ~r_cmd.addr : ADDR_W'(r_cmd.size);
        cin        = r_cmd.look_en;
        sum        = {1'b0, op_a} + {1'b0, op_b} + (ADDR_W+1)'(cin);
        new_end    = sum[ADDR_W] ? '1 : sum[ADDR_W-1:0];
        look_found = r_cmd.look_en && trk.best_hit && sum[ADDR_W]
                     && (sum[ADDR_W-1:0] != '0);
        full       = r_cmd.add_en && !trk.match_hit && !trk.free_hit;
        slot       = trk.match_hit ? trk.match_idx : trk.free_idx;
        ram_we     = (r_state == ST_CALC) && r_cmd.add_en && !full;
    end

    // valid bits: cleared by drops during the scan, set by the alloc write
    always_comb begin
        n_valid = r_valid;
        if (drop_hit) begin
            n_valid[r_pend_idx] = 1'b0;
        end
        if (ram_we) begin
            n_valid[slot] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // per-operation outcome
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CALC) begin
            r_found  <= look_found;
            r_rem    <= look_found ? sum[SIZE_W-1:0] : '0;
            r_full   <= full;
            r_add_ok <= ram_we;
        end
    end

    always_comb begin
        fin.commit = (r_state == ST_DONE);
        fin.add_ok = fin.commit && r_add_ok;
        fin.full   = r_full;
        fin.found  = fin.commit && r_found;
        fin.rem    = r_rem;
        fin.size   = r_cmd.size;
    end

    hrt_stats u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_thresh (r_thresh),
        .i_fin    (fin),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    // checks
    a_strobe_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state) == ST_DONE)
        else $error("result strobe without a finished operation");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted word did not make the block busy");

    a_scan_no_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |=> $countones(r_valid) <= $past($countones(r_valid)))
        else $error("valid bit set during the table scan");

    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_rsp.found && o_rsp.table_full))
        else $error("lookup hit and full table flagged together");

endmodule

// File: rtl/hrt_ram.sv
// Generic single write port RAM with registered read.
module hrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/hrt_scan.sv
// Per-entry compare unit: one table entry per cycle, tracks match, free slot and best lookup.
module hrt_scan import hrt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clr,
    input  logic              i_smp,
    input  t_cmd              i_cmd,
    input  logic [IDX_W-1:0]  i_idx,
    input  logic              i_vld,
    input  logic [ADDR_W-1:0] i_start,
    input  logic [ADDR_W-1:0] i_end,
    output logic              o_drop_hit,
    output t_track            o_trk
);

    t_track r_trk;
    t_track n_trk;
    logic   hit_drop;
    logic   is_match;
    logic   is_free;
    logic   is_cand;

    // compares on the entry being read out
    always_comb begin
        hit_drop = i_cmd.drop_en && i_vld && (i_start == i_cmd.addr);
        is_match = i_cmd.add_en && i_vld && (i_start == i_cmd.add_key);
        is_free  = !i_vld || hit_drop;
        is_cand  = i_cmd.look_en && i_vld && (i_start <= i_cmd.addr)
                   && (!r_trk.best_hit || (i_start > r_trk.best_start));
    end

    // tracker update: first match, lowest free, greatest start at or below addr
    always_comb begin
        n_trk = r_trk;
        if (i_clr) begin
            n_trk.match_hit = 1'b0;
            n_trk.free_hit  = 1'b0;
            n_trk.best_hit  = 1'b0;
        end else if (i_smp) begin
            if (is_match && !r_trk.match_hit) begin
                n_trk.match_hit = 1'b1;
                n_trk.match_idx = i_idx;
            end
            if (is_free && !r_trk.free_hit) begin
                n_trk.free_hit = 1'b1;
                n_trk.free_idx = i_idx;
            end
            if (is_cand) begin
                n_trk.best_hit   = 1'b1;
                n_trk.best_start = i_start;
                n_trk.best_end   = i_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trk <= '0;
        end else begin
            r_trk <= n_trk;
        end
    end

    assign o_drop_hit = i_smp && hit_drop;
    assign o_trk      = r_trk;

endmodule

// File: rtl/hrt_stats.sv
// Running statistics and the registered result word.
module hrt_stats import hrt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SIZE_W-1:0] i_thresh,
    input  t_fin              i_fin,
    output logic              o_strobe,
    output t_rsp              o_rsp
);

    logic [SIZE_W-1:0]  r_largest_obj, n_largest_obj;
    logic [CNT_W-1:0]   r_alloc_cnt,   n_alloc_cnt;
    logic [CNT_W-1:0]   r_big_cnt,     n_big_cnt;
    logic [SIZE_W-1:0]  r_largest_fnd, n_largest_fnd;
    logic [TOTAL_W-1:0] r_found_tot,   n_found_tot;
    logic [TOTAL_W:0]   tot_sum;
    logic               r_strobe;
    t_rsp               r_rsp, n_rsp;

    // next statistics
    always_comb begin
        n_largest_obj = r_largest_obj;
        n_alloc_cnt   = r_alloc_cnt;
        n_big_cnt     = r_big_cnt;
        n_largest_fnd = r_largest_fnd;
        n_found_tot   = r_found_tot;
        tot_sum       = {1'b0, r_found_tot} + (TOTAL_W+1)'(i_fin.rem);
        if (i_fin.add_ok) begin
            if (i_fin.size > r_largest_obj) begin
                n_largest_obj = i_fin.size;
            end
            if (r_alloc_cnt != '1) begin
                n_alloc_cnt = r_alloc_cnt + CNT_W'(1);
            end
            if ((i_fin.size >= i_thresh) && (r_big_cnt != '1)) begin
                n_big_cnt = r_big_cnt + CNT_W'(1);
            end
        end
        if (i_fin.found) begin
            if (i_fin.rem > r_largest_fnd) begin
                n_largest_fnd = i_fin.rem;
            end
            n_found_tot = tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
        end
        n_rsp.found              = i_fin.found;
        n_rsp.remaining_size     = i_fin.rem;
        n_rsp.table_full         = i_fin.full;
        n_rsp.largest_object_out = n_largest_obj;
        n_rsp.alloc_count_out    = n_alloc_cnt;
        n_rsp.big_count_out      = n_big_cnt;
        n_rsp.largest_found_out  = n_largest_fnd;
        n_rsp.found_total_out    = n_found_tot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_largest_obj <= '0;
            r_alloc_cnt   <= '0;
            r_big_cnt     <= '0;
            r_largest_fnd <= '0;
            r_found_tot   <= '0;
            r_strobe      <= 1'b0;
        end else begin
            r_strobe <= i_fin.commit;
            if (i_fin.commit) begin
                r_largest_obj <= n_largest_obj;
                r_alloc_cnt   <= n_alloc_cnt;
                r_big_cnt     <= n_big_cnt;
                r_largest_fnd <= n_largest_fnd;
                r_found_tot   <= n_found_tot;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_fin.commit) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

// File: tb/tb_heap_range_table.sv
// Self-checking testbench for heap_range_table: directed table plus random phases.
module tb_heap_range_table import hrt_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 200;
    localparam int NUM_PHASES     = 7;

    // directed row: command word and, where obvious, the result typed in
    typedef struct {
        t_req req;
        bit   golden_en;
        t_rsp golden;
    } t_dir_row;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    t_req              i_req       = '0;
    logic              o_strobe;
    t_rsp              o_rsp;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [SIZE_W-1:0] i_cfg_data  = '0;

    // shadow of the range table and its statistics
    bit                 tbl_valid [ENTRIES];
    logic [ADDR_W-1:0]  tbl_start [ENTRIES];
    logic [ADDR_W-1:0]  tbl_end   [ENTRIES];
    logic [SIZE_W-1:0]  big_thresh     = THRESH_RESET;
    logic [SIZE_W-1:0]  stat_largest   = '0;
    logic [CNT_W-1:0]   stat_allocs    = '0;
    logic [CNT_W-1:0]   stat_bigs      = '0;
    logic [SIZE_W-1:0]  stat_found_max = '0;
    logic [TOTAL_W-1:0] stat_found_sum = '0;

    t_rsp     pending_results [$];
    t_dir_row dir_q [$];
    int       err_count   = 0;
    int       idle_cycles = 0;

    heap_range_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_strobe    (o_strobe),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5ns i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // shadow table model
    // ---------------------------------------------------------------

    function automatic void remove_range(logic [ADDR_W-1:0] s);
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_start[i] == s)
                tbl_valid[i] = 1'b0;
    endfunction

    // returns 1 when no entry could take the range
    function automatic bit insert_range(logic [ADDR_W-1:0] s, logic [SIZE_W-1:0] sz);
        int          slot;
        logic [64:0] sum;
        slot = -1;
        if (s == '0)
            return 1'b0;
        for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && tbl_valid[i] && tbl_start[i] == s)
                slot = i;
        if (slot < 0)
            for (int i = 0; i < ENTRIES; i++)
                if (slot < 0 && !tbl_valid[i])
                    slot = i;
        if (slot < 0)
            return 1'b1;
        // end saturates at the top of the address space
        sum = {1'b0, s} + 65'(sz);
        tbl_valid[slot] = 1'b1;
        tbl_start[slot] = s;
        tbl_end[slot]   = sum[64] ? '1 : sum[63:0];
        if (sz > stat_largest)
            stat_largest = sz;
        if (stat_allocs != '1)
            stat_allocs++;
        if (sz >= big_thresh && stat_bigs != '1)
            stat_bigs++;
        return 1'b0;
    endfunction

    // applies one command word to the shadow table, returns the result word
    function automatic t_rsp apply_heap_op(t_req w);
        t_rsp              r;
        int                best;
        logic [ADDR_W-1:0] diff;
        r    = '0;
        best = -1;
        case (w.opcode)
            OP_ALLOC: begin
                r.table_full = insert_range(w.addr, w.size);
            end
            OP_REALLOC: begin
                if (w.addr == '0) begin
                    r.table_full = insert_range(w.new_addr, w.size);
                end else if (w.size == '0) begin
                    remove_range(w.addr);
                end else begin
                    if (w.addr != w.new_addr && w.new_addr != '0)
                        remove_range(w.addr);
                    r.table_full = insert_range(w.new_addr, w.size);
                end
            end
            OP_FREE: begin
                remove_range(w.addr);
            end
            default: begin
                // nearest live start at or below the address
                for (int i = 0; i < ENTRIES; i++)
                    if (tbl_valid[i] && tbl_start[i] <= w.addr &&
                        (best < 0 || tbl_start[i] > tbl_start[best]))
                        best = i;
                if (best >= 0 && w.addr < tbl_end[best]) begin
                    diff             = tbl_end[best] - w.addr;
                    r.found          = 1'b1;
                    r.remaining_size = diff[SIZE_W-1:0];
                    if (r.remaining_size > stat_found_max)
                        stat_found_max = r.remaining_size;
                    if (stat_found_sum > ~TOTAL_W'(r.remaining_size))
                        stat_found_sum = '1;
                    else
                        stat_found_sum += TOTAL_W'(r.remaining_size);
                end
            end
        endcase
        r.largest_object_out = stat_largest;
        r.alloc_count_out    = stat_allocs;
        r.big_count_out      = stat_bigs;
        r.largest_found_out  = stat_found_max;
        r.found_total_out    = stat_found_sum;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic t_req cmd_word(t_op op, logic [ADDR_W-1:0] a,
                                      logic [ADDR_W-1:0] na, logic [SIZE_W-1:0] sz);
        t_req w;
        w.opcode   = op;
        w.addr     = a;
        w.new_addr = na;
        w.size     = sz;
        return w;
    endfunction

    function automatic t_rsp stats_word(bit f, logic [SIZE_W-1:0] rem, bit full,
                                        logic [SIZE_W-1:0] lo, logic [CNT_W-1:0] ac,
                                        logic [CNT_W-1:0] bc, logic [SIZE_W-1:0] lf,
                                        logic [TOTAL_W-1:0] ft);
        t_rsp r;
        r.found              = f;
        r.remaining_size     = rem;
        r.table_full         = full;
        r.largest_object_out = lo;
        r.alloc_count_out    = ac;
        r.big_count_out      = bc;
        r.largest_found_out  = lf;
        r.found_total_out    = ft;
        return r;
    endfunction

    function automatic t_dir_row dir_entry(t_req w, bit g, t_rsp e);
        t_dir_row d;
        d.req       = w;
        d.golden_en = g;
        d.golden    = e;
        return d;
    endfunction

    // appends one directed row to the table
    function automatic void add_row(t_req w, bit g, t_rsp e);
        dir_q.insert(dir_q.size(), dir_entry(w, g, e));
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i])
                n++;
        return n;
    endfunction

    // index of a random live entry, -1 on an empty table
    function automatic int pick_live();
        int n, k;
        n = live_count();
        if (n == 0)
            return -1;
        k = $urandom_range(0, n - 1);
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i]) begin
                if (k == 0)
                    return i;
                k--;
            end
        return -1;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        int q;
        q = $urandom_range(0, 99);
        if (q < 3)
            return '0;
        if (q < 8)
            return {$urandom, $urandom};
        if (q < 12)
            return ~ADDR_W'($urandom_range(0, 4096));
        // dense heap region so that ranges collide and overlap
        return 64'h0000_7f00_0000_0000 + ADDR_W'($urandom_range(0, 4095)) * 256;
    endfunction

    function automatic logic [ADDR_W-1:0] live_start();
        int idx;
        idx = pick_live();
        return (idx < 0) ? rand_addr() : tbl_start[idx];
    endfunction

    function automatic logic [SIZE_W-1:0] rand_size();
        int q;
        q = $urandom_range(0, 99);
        if (q < 5)
            return '0;
        if (q < 10)
            return '1;
        if (q < 16)
            return SIZE_W'({$urandom, $urandom});
        if (q < 26)
            return big_thresh + SIZE_W'($urandom_range(0, 2)) - SIZE_W'(1);
        return SIZE_W'($urandom_range(1, 'h2000));
    endfunction

    // mostly live addresses; the rest is noise
    function automatic t_req random_word(int alloc_pct);
        t_req              w;
        int                idx, q, pct;
        logic [ADDR_W-1:0] span;
        pct        = (live_count() > 56 && alloc_pct < 80) ? 15 : alloc_pct;
        w.size     = rand_size();
        w.new_addr = {$urandom, $urandom};
        if ($urandom_range(0, 99) < pct) begin
            w.opcode = OP_ALLOC;
            w.addr   = ($urandom_range(0, 9) == 0) ? live_start() : rand_addr();
        end else begin
            q = $urandom_range(0, 99);
            if (q < 25) begin
                w.opcode = OP_REALLOC;
                q = $urandom_range(0, 99);
                w.addr = (q < 10) ? '0 : (q < 80) ? live_start() : rand_addr();
                q = $urandom_range(0, 99);
                w.new_addr = (q < 30) ? w.addr : (q < 40) ? '0 : rand_addr();
            end else if (q < 55) begin
                w.opcode = OP_FREE;
                w.addr   = ($urandom_range(0, 9) < 8) ? live_start() : rand_addr();
            end else begin
                w.opcode = OP_LOOKUP;
                idx = pick_live();
                q   = $urandom_range(0, 99);
                if (idx < 0 || q < 15) begin
                    w.addr = rand_addr();
                end else if (q < 25) begin
                    w.addr = tbl_start[idx] - 1;
                end else if (q < 35) begin
                    w.addr = tbl_end[idx];
                end else begin
                    span   = tbl_end[idx] - tbl_start[idx];
                    if (span > 'h4000)
                        span = 'h4000;
                    w.addr = tbl_start[idx] + ADDR_W'($urandom_range(0, span[31:0]));
                end
            end
        end
        return w;
    endfunction

    // mostly short gaps, a few longer than a whole operation
    function automatic int rand_gap(bit calm);
        int q;
        if (calm)
            return 0;
        q = $urandom_range(0, 99);
        if (q < 40)
            return 0;
        if (q < 85)
            return $urandom_range(1, 3);
        if (q < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, 150);
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    task automatic send_word(t_req w, int gap, bit use_golden, t_rsp golden);
        t_rsp want;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= w;
        do @(posedge i_clk); while (busy !== 1'b0);
        want = apply_heap_op(w);
        pending_results.insert(pending_results.size(), use_golden ? golden : want);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0 || busy !== 1'b0)
            @(posedge i_clk);
    endtask

    task automatic write_thresh(logic [SIZE_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        big_thresh = v;
    endtask

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    task automatic check_word(t_rsp got, t_rsp want);
        if (got.found !== want.found)
            flag_mismatch("found", got.found, want.found);
        if (got.remaining_size !== want.remaining_size)
            flag_mismatch("remaining_size", got.remaining_size, want.remaining_size);
        if (got.table_full !== want.table_full)
            flag_mismatch("table_full", got.table_full, want.table_full);
        if (got.largest_object_out !== want.largest_object_out)
            flag_mismatch("largest_object_out", got.largest_object_out,
                          want.largest_object_out);
        if (got.alloc_count_out !== want.alloc_count_out)
            flag_mismatch("alloc_count_out", got.alloc_count_out, want.alloc_count_out);
        if (got.big_count_out !== want.big_count_out)
            flag_mismatch("big_count_out", got.big_count_out, want.big_count_out);
        if (got.largest_found_out !== want.largest_found_out)
            flag_mismatch("largest_found_out", got.largest_found_out,
                          want.largest_found_out);
        if (got.found_total_out !== want.found_total_out)
            flag_mismatch("found_total_out", got.found_total_out, want.found_total_out);
    endtask

    // result words against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_results.size() == 0)
                flag_mismatch("result word with none expected", o_rsp.found_total_out, '0);
            else
                check_word(o_rsp, pending_results.pop_front());
        end
    end

    // watchdog: cycles without any accepted word, result strobe or threshold write
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_strobe === 1'b1 ||
            (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial begin
        int                alloc_pct;
        bit                calm;
        logic [SIZE_W-1:0] thr;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, threshold at its reset value
        add_row(cmd_word(OP_LOOKUP, 64'h1000, 0, 0), 1,
                stats_word(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(cmd_word(OP_FREE, 64'h1000, 0, 0), 1,
                stats_word(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(cmd_word(OP_ALLOC, 64'h0, 0, 48'h64), 1,
                stats_word(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(cmd_word(OP_ALLOC, 64'h1000, 0, 48'h100), 1,
                stats_word(0, 0, 0, 48'h100, 1, 0, 0, 0));
        add_row(cmd_word(OP_ALLOC, 64'h2000, 0, 48'h1000), 1,
                stats_word(0, 0, 0, 48'h1000, 2, 1, 0, 0));
        add_row(cmd_word(OP_LOOKUP, 64'h1000, 0, 0), 1,
                stats_word(1, 48'h100, 0, 48'h1000, 2, 1, 48'h100, 64'h100));
        add_row(cmd_word(OP_LOOKUP, 64'h10ff, 0, 0), 1,
                stats_word(1, 48'h1, 0, 48'h1000, 2, 1, 48'h100, 64'h101));
        // one past the end, and below the lowest start
        add_row(cmd_word(OP_LOOKUP, 64'h1100, 0, 0), 1,
                stats_word(0, 0, 0, 48'h1000, 2, 1, 48'h100, 64'h101));
        add_row(cmd_word(OP_LOOKUP, 64'h0fff, 0, 0), 1,
                stats_word(0, 0, 0, 48'h1000, 2, 1, 48'h100, 64'h101));
        // overwrite of a live start, zero size
        add_row(cmd_word(OP_ALLOC, 64'h1000, 0, 48'h20), 0, '0);
        add_row(cmd_word(OP_ALLOC, 64'h3000, 0, 48'h0), 0, '0);
        // realloc: null old pointer, size zero, move, in place, null new pointer
        add_row(cmd_word(OP_REALLOC, 64'h0, 64'h4000, 48'h40), 0, '0);
        add_row(cmd_word(OP_REALLOC, 64'h4000, 64'h9999, 48'h0), 0, '0);
        add_row(cmd_word(OP_REALLOC, 64'h2000, 64'h5000, 48'h80), 0, '0);
        add_row(cmd_word(OP_REALLOC, 64'h1000, 64'h1000, 48'h300), 0, '0);
        add_row(cmd_word(OP_REALLOC, 64'h5000, 64'h0, 48'h10), 0, '0);
        add_row(cmd_word(OP_FREE, 64'h1000, 0, 0), 0, '0);
        add_row(cmd_word(OP_FREE, 64'h7777, 0, 0), 0, '0);
        // largest size, end above the address space, top address
        add_row(cmd_word(OP_ALLOC, 64'h8000_0000_0000_0000, '1, '1), 0, '0);
        add_row(cmd_word(OP_LOOKUP, 64'h8000_0000_0000_0000, '1, '1), 0, '0);
        add_row(cmd_word(OP_ALLOC, '1, 0, 48'h5), 0, '0);
        add_row(cmd_word(OP_LOOKUP, '1, 0, 0), 0, '0);
        add_row(cmd_word(OP_LOOKUP, 64'hffff_ffff_ffff_ff00, 0, 0), 0, '0);
        add_row(cmd_word(OP_LOOKUP, 64'h3000, 0, 0), 0, '0);

        foreach (dir_q[n])
            send_word(dir_q[n].req, rand_gap(1'b0), dir_q[n].golden_en, dir_q[n].golden);

        // random phases, one threshold setting each
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            alloc_pct = 35;
            case (ph)
                0: thr = '0;
                1: begin
                    thr = '1;
                    alloc_pct = 85;     // fill the table until allocs bounce
                end
                2: begin
                    thr = SIZE_W'(1);
                    alloc_pct = 10;     // drain toward an empty table
                end
                3: thr = THRESH_RESET;
                4: thr = SIZE_W'({$urandom, $urandom});
                5: thr = SIZE_W'($urandom_range(1, 'h2000));
                default: begin
                    thr = '1;
                    alloc_pct = 50;
                end
            endcase
            write_thresh(thr);
            calm = (ph == 3 || ph == 5);
            repeat (PHASE_WORDS)
                send_word(random_word(alloc_pct), rand_gap(calm), 1'b0, '0);
        end

        wait_idle();
        repeat (ENTRIES + 8) @(posedge i_clk);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
